### hdl/dmeq_pkg.sv
// ----------------------------------------------------------------------------
// dmeq_pkg: shared types and constants of the dual mode event queue
// Word layouts, command and mode codes, and the per-cell operation code.
// ----------------------------------------------------------------------------
package dmeq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int KEY_W     = 32;
    localparam int KIND_W    = 4;
    localparam int OWNER_W   = 8;
    localparam int OCC_W     = 7;

    localparam logic CMD_INSERT    = 1'b0;
    localparam logic CMD_REMOVE    = 1'b1;
    localparam logic MODE_FCFS     = 1'b0;
    localparam logic MODE_PRIORITY = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [KEY_W-1:0]   event_key;
        logic [KIND_W-1:0]  event_kind;
        logic [OWNER_W-1:0] owner_id;
    } t_in_word;

    typedef struct packed {
        logic               out_valid;
        logic [KEY_W-1:0]   out_key;
        logic [KIND_W-1:0]  out_kind;
        logic [OWNER_W-1:0] out_owner;
        logic               is_empty;
        logic [OCC_W-1:0]   occupancy;
        logic               dropped;
    } t_out_word;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [KIND_W-1:0]  kind;
        logic [OWNER_W-1:0] owner;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_NEW,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_op;

endpackage

### hdl/dmeq_cell.sv
// ----------------------------------------------------------------------------
// dmeq_cell: one queue slot
// Holds one entry and its valid flag; loads the new entry, takes its left
// neighbor (shift toward the rear) or its right neighbor (shift to front).
// ----------------------------------------------------------------------------
module dmeq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dmeq_pkg::t_cell_op i_op,
    input  dmeq_pkg::t_entry  i_new,
    input  dmeq_pkg::t_entry  i_left,
    input  logic              i_left_valid,
    input  dmeq_pkg::t_entry  i_right,
    input  logic              i_right_valid,
    output dmeq_pkg::t_entry  o_entry,
    output logic              o_valid,
    output logic              o_gt
);

    dmeq_pkg::t_entry r_entry;
    dmeq_pkg::t_entry n_entry;
    logic             r_valid;
    logic             n_valid;

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        case (i_op)
            dmeq_pkg::CELL_HOLD: begin
                n_entry = r_entry;
                n_valid = r_valid;
            end
            dmeq_pkg::CELL_LOAD_NEW: begin
                n_entry = i_new;
                n_valid = 1'b1;
            end
            dmeq_pkg::CELL_FROM_LEFT: begin
                n_entry = i_left;
                n_valid = i_left_valid;
            end
            dmeq_pkg::CELL_FROM_RIGHT: begin
                n_entry = i_right;
                n_valid = i_right_valid;
            end
            default: begin
                n_entry = r_entry;
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;
    assign o_gt    = r_valid && (r_entry.key > i_new.key);

endmodule

### hdl/dual_mode_event_queue.sv
// ----------------------------------------------------------------------------
// dual_mode_event_queue: bounded event queue, FIFO or stable priority order
// Usage:
//   Input channel i_valid / o_stall carries one command word: insert an event
//   (key, kind, owner) or remove the front event. Output channel o_valid /
//   i_stall returns one result word per command: the removed entry, emptiness,
//   occupancy and a drop flag for an insert into a full queue.
//   i_cfg_we / i_cfg_data set the mode: 0 arrival order, 1 ascending key with
//   equal keys kept in arrival order. Write it only while the queue is idle.
//   Entries live in a row of DEPTH cells; the front is cell 0. Every cell
//   compares its key to the incoming key at once and the row shifts by one
//   cell, all cells together.
//   Each result is registered and shows in the cycle after accept; one
//   command is taken every cycle, bounded by the single result register:
//   while a result waits under i_stall, o_stall is high and none is taken.
//   Reset (synchronous, active low) empties the queue, selects arrival order
//   and drops any waiting result; entry payloads are not cleared.
// ----------------------------------------------------------------------------
module dual_mode_event_queue #(
    parameter int DEPTH = dmeq_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  dmeq_pkg::t_in_word  i_in_word,
    output logic                o_valid,
    input  logic                i_stall,
    output dmeq_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                r_mode;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_ovalid;
    dmeq_pkg::t_out_word r_out;
    dmeq_pkg::t_out_word n_out;

    dmeq_pkg::t_entry    w_new;
    dmeq_pkg::t_entry    w_entry [DEPTH];
    dmeq_pkg::t_cell_op  w_op    [DEPTH];
    logic [DEPTH-1:0]    w_valid;
    logic [DEPTH-1:0]    w_gt;
    logic [DEPTH-1:0]    w_low;
    logic [DEPTH-1:0]    w_stay;
    logic                w_acc;
    logic                w_full;
    logic                w_empty;
    logic                w_ins;
    logic                w_rem;

    assign o_stall = r_ovalid && i_stall;
    assign w_acc   = i_valid && !o_stall;
    assign w_full  = w_valid[DEPTH-1];
    assign w_empty = !w_valid[0];
    assign w_ins   = w_acc && (i_in_word.cmd == dmeq_pkg::CMD_INSERT) && !w_full;
    assign w_rem   = w_acc && (i_in_word.cmd == dmeq_pkg::CMD_REMOVE) && !w_empty;

    assign w_new.key   = i_in_word.event_key;
    assign w_new.kind  = i_in_word.event_kind;
    assign w_new.owner = i_in_word.owner_id;

    // cells before the insert point hold
    assign w_low = w_gt & (~w_gt + DEPTH'(1));
    always_comb begin
        if ((r_mode == dmeq_pkg::MODE_PRIORITY) && (|w_gt)) begin
            w_stay = w_low - DEPTH'(1);
        end else begin
            w_stay = w_valid;
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_op[i] = dmeq_pkg::CELL_HOLD;
            if (w_ins && !w_stay[i]) begin
                if (i == 0) begin
                    w_op[i] = dmeq_pkg::CELL_LOAD_NEW;
                end else if (w_stay[i-1]) begin
                    w_op[i] = dmeq_pkg::CELL_LOAD_NEW;
                end else begin
                    w_op[i] = dmeq_pkg::CELL_FROM_LEFT;
                end
            end else if (w_rem) begin
                w_op[i] = dmeq_pkg::CELL_FROM_RIGHT;
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        dmeq_pkg::t_entry w_left;
        dmeq_pkg::t_entry w_right;
        logic             w_left_valid;
        logic             w_right_valid;

        if (g == 0) begin : g_first
            assign w_left       = w_new;
            assign w_left_valid = 1'b0;
        end else begin : g_mid_l
            assign w_left       = w_entry[g-1];
            assign w_left_valid = w_valid[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right       = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_mid_r
            assign w_right       = w_entry[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        dmeq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (w_op[g]),
            .i_new         (w_new),
            .i_left        (w_left),
            .i_left_valid  (w_left_valid),
            .i_right       (w_right),
            .i_right_valid (w_right_valid),
            .o_entry       (w_entry[g]),
            .o_valid       (w_valid[g]),
            .o_gt          (w_gt[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_out           = '0;
        n_out.is_empty  = (n_count == '0);
        n_out.occupancy = dmeq_pkg::OCC_W'(n_count);
        n_out.dropped   = (i_in_word.cmd == dmeq_pkg::CMD_INSERT) && w_full;
        if (w_rem) begin
            n_out.out_valid = 1'b1;
            n_out.out_key   = w_entry[0].key;
            n_out.out_kind  = w_entry[0].kind;
            n_out.out_owner = w_entry[0].owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= dmeq_pkg::MODE_FCFS;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_count <= n_count;
            if (w_acc) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_out_word = r_out;

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_count))
        else $error("occupancy count disagrees with valid cells");

    a_valid_thermometer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid & ~(w_valid >> 1)) == '0) || $onehot(w_valid & ~(w_valid >> 1)))
        else $error("valid cells not contiguous from the front");

    a_remove_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_in_word.cmd == dmeq_pkg::CMD_REMOVE) && w_valid[0]
        |=> o_valid && o_out_word.out_valid)
        else $error("remove on non-empty queue returned no entry");

    a_drop_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_in_word.cmd == dmeq_pkg::CMD_INSERT) && w_full
        |=> o_out_word.dropped && (r_count == $past(r_count)))
        else $error("insert into full queue changed the store");

endmodule

### bench/tb_dual_mode_event_queue.sv
// ----------------------------------------------------------------------------
// tb_dual_mode_event_queue: self-checking bench for the dual mode event queue
// Drives insert and remove words through the valid/stall input channel and
// checks every result word against an in-bench model of the entry store, in
// both arrival-order and key-order modes, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_dual_mode_event_queue;

    localparam int DEPTH       = dmeq_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_valid    = 1'b0;
    logic                o_stall;
    dmeq_pkg::t_in_word  i_in_word  = '0;
    logic                o_valid;
    logic                i_stall    = 1'b0;
    dmeq_pkg::t_out_word o_out_word;
    logic                i_cfg_we   = 1'b0;
    logic                i_cfg_data = 1'b0;

    dmeq_pkg::t_entry    held_entries[$];
    dmeq_pkg::t_out_word pending_results[$];
    logic                queue_mode_now = dmeq_pkg::MODE_FCFS;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int cycle_count     = 0;
    int mismatch_count  = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int drop_count      = 0;
    int empty_removes   = 0;
    int key_order_rems  = 0;
    int mode_writes     = 0;

    dual_mode_event_queue #(.DEPTH(DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_word  (i_in_word),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_word (o_out_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic dmeq_pkg::t_out_word apply_command(dmeq_pkg::t_in_word w);
        dmeq_pkg::t_out_word r;
        dmeq_pkg::t_entry    e;
        int                  pos;
        r = '0;
        if (w.cmd == dmeq_pkg::CMD_INSERT) begin
            if (held_entries.size() >= DEPTH) begin
                r.dropped = 1'b1;
            end else begin
                pos = held_entries.size();
                if (queue_mode_now == dmeq_pkg::MODE_PRIORITY) begin
                    for (int i = 0; i < held_entries.size(); i++) begin
                        if (held_entries[i].key > w.event_key) begin
                            pos = i;
                            break;
                        end
                    end
                end
                e.key   = w.event_key;
                e.kind  = w.event_kind;
                e.owner = w.owner_id;
                held_entries.insert(pos, e);
            end
        end else if (held_entries.size() > 0) begin
            e           = held_entries.pop_front();
            r.out_valid = 1'b1;
            r.out_key   = e.key;
            r.out_kind  = e.kind;
            r.out_owner = e.owner;
        end
        r.is_empty  = (held_entries.size() == 0);
        r.occupancy = dmeq_pkg::OCC_W'(held_entries.size());
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: random stall and result checking
    always @(posedge i_clk) begin
        dmeq_pkg::t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expected result waiting");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_valid", 32'(want.out_valid), 32'(o_out_word.out_valid));
                check_field("out_key",   want.out_key,        o_out_word.out_key);
                check_field("out_kind",  32'(want.out_kind),  32'(o_out_word.out_kind));
                check_field("out_owner", 32'(want.out_owner), 32'(o_out_word.out_owner));
                check_field("is_empty",  32'(want.is_empty),  32'(o_out_word.is_empty));
                check_field("occupancy", 32'(want.occupancy), 32'(o_out_word.occupancy));
                check_field("dropped",   32'(want.dropped),   32'(o_out_word.dropped));
                results_checked++;
            end
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_word(input dmeq_pkg::t_in_word w);
        dmeq_pkg::t_out_word r;
        i_valid   <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_stall);
        r = apply_command(w);
        pending_results.insert(pending_results.size(), r);
        words_sent++;
        if (r.dropped) drop_count++;
        if (w.cmd == dmeq_pkg::CMD_REMOVE && !r.out_valid) empty_removes++;
        if (w.cmd == dmeq_pkg::CMD_REMOVE && r.out_valid &&
            queue_mode_now == dmeq_pkg::MODE_PRIORITY)
            key_order_rems++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic insert_event(input logic [31:0] key, input logic [3:0] kind,
                                input logic [7:0] owner);
        dmeq_pkg::t_in_word w;
        w.cmd        = dmeq_pkg::CMD_INSERT;
        w.event_key  = key;
        w.event_kind = kind;
        w.owner_id   = owner;
        send_word(w);
    endtask

    task automatic remove_front();
        dmeq_pkg::t_in_word w;
        w.cmd        = dmeq_pkg::CMD_REMOVE;
        w.event_key  = $urandom;
        w.event_kind = 4'($urandom);
        w.owner_id   = 8'($urandom);
        send_word(w);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        queue_mode_now = m;
        mode_writes++;
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(3))
            0:       return $urandom_range(7);
            1:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            2:       return 32'hFFFF_FFF0 | $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    function automatic dmeq_pkg::t_in_word make_word(input int insert_pct);
        dmeq_pkg::t_in_word w;
        w.event_key  = pick_key();
        w.event_kind = 4'($urandom);
        w.owner_id   = 8'($urandom);
        w.cmd        = ($urandom_range(99) < insert_pct) ? dmeq_pkg::CMD_INSERT
                                                         : dmeq_pkg::CMD_REMOVE;
        return w;
    endfunction

    task automatic test_remove_on_empty();
        remove_front();
        wait_idle();
    endtask

    task automatic test_arrival_order();
        set_mode(dmeq_pkg::MODE_FCFS);
        insert_event(32'hFFFF_FFFF, 4'hF, 8'hFF);
        insert_event(32'h0,         4'h0, 8'h00);
        insert_event(32'h5A5A_A5A5, 4'h9, 8'h3C);
        repeat (4) remove_front();
        wait_idle();
    endtask

    task automatic test_key_order();
        set_mode(dmeq_pkg::MODE_PRIORITY);
        insert_event(32'd5,         4'h1, 8'h01);
        insert_event(32'hFFFF_FFFF, 4'h2, 8'h02);
        insert_event(32'd0,         4'h3, 8'h03);
        insert_event(32'd5,         4'h4, 8'h04);
        repeat (4) remove_front();
        wait_idle();
    endtask

    task automatic test_mode_switch_with_entries();
        set_mode(dmeq_pkg::MODE_FCFS);
        insert_event(32'd9, 4'h5, 8'h10);
        insert_event(32'd3, 4'h6, 8'h11);
        insert_event(32'd7, 4'h7, 8'h12);
        set_mode(dmeq_pkg::MODE_PRIORITY);
        insert_event(32'd8, 4'h8, 8'h13);
        set_mode(dmeq_pkg::MODE_FCFS);
        insert_event(32'd1, 4'hA, 8'h14);
        repeat (5) remove_front();
        wait_idle();
    endtask

    task automatic test_full_store(input logic m);
        set_mode(m);
        while (held_entries.size() < DEPTH) begin
            insert_event(pick_key(), 4'($urandom), 8'($urandom));
        end
        repeat (3) insert_event(pick_key(), 4'($urandom), 8'($urandom));
        remove_front();
        insert_event(pick_key(), 4'($urandom), 8'($urandom));
        insert_event(pick_key(), 4'($urandom), 8'($urandom));
        repeat (DEPTH + 1) remove_front();
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n_items);
        int left;
        int burst;
        int insert_pct;
        left = n_items;
        while (left > 0) begin
            burst = $urandom_range(16, 80);
            case ($urandom_range(3))
                0:       insert_pct = 15;
                1:       insert_pct = 50;
                2:       insert_pct = 70;
                default: insert_pct = 95;
            endcase
            for (int i = 0; i < burst && left > 0; i++) begin
                send_word(make_word(insert_pct));
                left--;
            end
            if ($urandom_range(3) == 0)
                set_mode(queue_mode_now == dmeq_pkg::MODE_FCFS ? dmeq_pkg::MODE_PRIORITY
                                                               : dmeq_pkg::MODE_FCFS);
        end
        wait_idle();
    endtask

    initial begin
        send_idle_pct = 37;
        recv_idle_pct = 54;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_remove_on_empty();
        test_arrival_order();
        test_key_order();
        test_mode_switch_with_entries();
        test_full_store(dmeq_pkg::MODE_FCFS);
        test_random_traffic(480);

        send_idle_pct = 54;
        recv_idle_pct = 37;
        test_full_store(dmeq_pkg::MODE_PRIORITY);
        test_random_traffic(480);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(480);

        wait_idle();
        repeat (5) @(posedge i_clk);
        $display("Covered %0d command words and %0d result words over %0d mode writes.",
                 words_sent, results_checked, mode_writes);
        $display("Full-queue drops %0d, removes on empty %0d, key-order removes %0d.",
                 drop_count, empty_removes, key_order_rems);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
